/* design/mlfd_pkg.sv */
// Shared types, codes and the segment lookup for the meter LCD frame decoder.
// No dependencies; imported by mlfd_decode and meter_lcd_frame_decoder_core.
`default_nettype none

package mlfd_pkg;

	localparam int FRAME_BYTES = 14;
	localparam int DIGIT_COUNT = 4;
	localparam int NIBBLES     = 2 * DIGIT_COUNT;

	localparam logic [3:0] COUNT_MAX   = 4'd15;
	localparam logic [3:0] FRAME_LEN   = 4'(FRAME_BYTES);
	localparam logic [3:0] FIRST_STORE = 4'd2;
	localparam logic [3:0] LAST_STORE  = 4'(FIRST_STORE + NIBBLES - 1);

	localparam logic       CMD_BYTE = 1'b0;
	localparam logic       CMD_GAP  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SEQ  = 2'd1;
	localparam logic [1:0] ST_NO_NUM   = 2'd2;

	localparam logic [3:0] CODE_L       = 4'd10;
	localparam logic [3:0] CODE_BLANK   = 4'd11;
	localparam logic [3:0] CODE_UNKNOWN = 4'd12;
	localparam logic [3:0] CODE_POINT   = 4'd13;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  digit_a;
		logic [3:0]  digit_b;
		logic [3:0]  digit_c;
		logic [3:0]  digit_d;
		logic [3:0]  point_mask;
		logic [13:0] mantissa;
		logic [2:0]  decimals;
	} out_item_t;

	typedef logic [3:0] nibble_t;

	// Maps a seven-segment pattern to a digit code.
	function automatic logic [3:0] seg_to_code(input logic [6:0] pattern);
		logic [3:0] code;
		unique case (pattern)
			7'h7d:   code = 4'd0;
			7'h05:   code = 4'd1;
			7'h5b:   code = 4'd2;
			7'h1f:   code = 4'd3;
			7'h27:   code = 4'd4;
			7'h3e:   code = 4'd5;
			7'h7e:   code = 4'd6;
			7'h15:   code = 4'd7;
			7'h7f:   code = 4'd8;
			7'h3f:   code = 4'd9;
			7'h68:   code = CODE_L;
			7'h00:   code = CODE_BLANK;
			default: code = CODE_UNKNOWN;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

/* design/mlfd_decode.sv */
// Combinational decode of the stored display nibbles into digit codes and a number.
// Depends on mlfd_pkg.
`default_nettype none

module mlfd_decode
	import mlfd_pkg::*;
(
	input  wire nibble_t   nibbles [NIBBLES],
	output out_item_t      decoded
);

	localparam int SLOTS = 2 * DIGIT_COUNT;

	localparam logic [1:0] PH_ZERO  = 2'd0;
	localparam logic [1:0] PH_BLANK = 2'd1;
	localparam logic [1:0] PH_PARSE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [3:0] codes [DIGIT_COUNT];
	logic [DIGIT_COUNT-1:0] points;
	logic [3:0] sym [SLOTS];
	logic [SLOTS-1:0] sym_present;

	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			codes[i]  = seg_to_code({nibbles[2*i][2:0], nibbles[2*i+1]});
			points[i] = nibbles[2*i][3];
			// Each digit owns two text slots: an optional point, then its character.
			sym[2*i]           = CODE_POINT;
			sym_present[2*i]   = points[i];
			sym[2*i+1]         = codes[i];
			sym_present[2*i+1] = 1'b1;
		end
	end

	always_comb begin
		logic [1:0]  phase;
		logic        point_seen;
		logic [13:0] mant;
		logic [2:0]  ndig;
		logic [2:0]  dec;
		phase      = PH_ZERO;
		point_seen = 1'b0;
		mant       = '0;
		ndig       = '0;
		dec        = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (sym_present[k]) begin
				if (phase == PH_ZERO && sym[k] != 4'd0)
					phase = PH_BLANK;
				if (phase == PH_BLANK && sym[k] != CODE_BLANK)
					phase = PH_PARSE;
				if (phase == PH_PARSE) begin
					if (sym[k] <= 4'd9) begin
						mant = {mant[10:0], 3'b000} + {mant[12:0], 1'b0} + {10'd0, sym[k]};
						ndig = ndig + 3'd1;
						if (point_seen)
							dec = dec + 3'd1;
					end else if (sym[k] == CODE_POINT && !point_seen) begin
						point_seen = 1'b1;
					end else begin
						phase = PH_DONE;
					end
				end
			end
		end

		decoded.digit_a    = codes[0];
		decoded.digit_b    = codes[1];
		decoded.digit_c    = codes[2];
		decoded.digit_d    = codes[3];
		decoded.point_mask = points;
		// A display of nothing but zeros strips to an empty text and reads as zero.
		if (phase == PH_ZERO) begin
			decoded.status   = ST_OK;
			decoded.mantissa = '0;
			decoded.decimals = '0;
		end else if (ndig == 3'd0) begin
			decoded.status   = ST_NO_NUM;
			decoded.mantissa = '0;
			decoded.decimals = '0;
		end else begin
			decoded.status   = ST_OK;
			decoded.mantissa = mant;
			decoded.decimals = dec;
		end
	end

endmodule

`default_nettype wire

/* design/meter_lcd_frame_decoder_core.sv */
// A frame-ending gap transaction shows its result in the cycle after acceptance.
// Throughput: one input transaction per cycle; bytes are taken even while a result is
// stalled, a gap waits only while the single output register holds an untaken result.
// The decode of the four digits is one combinational pass into that output register.
// Reset clears the byte count, sets the sequence flag and empties the output register;
// the nibble store is not reset, a full frame always rewrites it.
`default_nettype none

module meter_lcd_frame_decoder_core
	import mlfd_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            item_valid,
	output logic           item_stall,
	input  wire in_item_t  item,
	output logic           result_valid,
	input  wire            result_stall,
	output out_item_t      result
);

	logic [3:0] count_q;
	logic       seq_ok_q;
	nibble_t    nib_q [NIBBLES];
	logic       out_valid_q;
	out_item_t  out_q;

	logic       item_acc;
	logic       out_acc;
	logic       is_byte;
	logic       is_gap;
	logic       frame_done;
	logic [3:0] next_pos;
	logic [2:0] store_off;
	out_item_t  decoded;
	out_item_t  result_d;

	mlfd_decode u_decode (
		.nibbles (nib_q),
		.decoded (decoded)
	);

	assign item_stall = out_valid_q & result_stall & (item.command == CMD_GAP);
	assign item_acc   = item_valid & ~item_stall;
	assign out_acc    = out_valid_q & ~result_stall;
	assign is_byte    = item_acc & (item.command == CMD_BYTE);
	assign is_gap     = item_acc & (item.command == CMD_GAP);
	assign frame_done = is_gap & (count_q == FRAME_LEN);
	assign next_pos   = count_q + 4'd1;
	assign store_off  = next_pos[2:0] - FIRST_STORE[2:0];

	always_comb begin
		if (seq_ok_q) begin
			result_d = decoded;
		end else begin
			result_d        = '0;
			result_d.status = ST_BAD_SEQ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			seq_ok_q <= 1'b1;
		end else if (is_gap) begin
			count_q  <= '0;
			seq_ok_q <= 1'b1;
		end else if (is_byte && count_q != COUNT_MAX) begin
			count_q <= next_pos;
			if (item.byte_value[7:4] != next_pos)
				seq_ok_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte && count_q != COUNT_MAX &&
		    next_pos >= FIRST_STORE && next_pos <= LAST_STORE)
			nib_q[store_off] <= item.byte_value[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_done) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done)
			out_q <= result_d;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(is_byte && count_q == COUNT_MAX) |=> (count_q == COUNT_MAX))
		else $error("byte count left saturation");

	a_gap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		is_gap |=> (count_q == 4'd0 && seq_ok_q))
		else $error("gap did not clear frame state");

	a_result_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> result_valid)
		else $error("complete frame gave no result");

	a_no_result_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(is_gap && count_q != FRAME_LEN && !out_valid_q) |=> !result_valid)
		else $error("result from a frame of wrong length");

	a_bad_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_BAD_SEQ) |->
		(result.mantissa == '0 && result.point_mask == '0 && result.digit_a == '0))
		else $error("bad sequence result carries data");
`endif

endmodule

`default_nettype wire

/* dv/meter_lcd_frame_decoder_core_test.sv */
// Self-checking testbench for meter_lcd_frame_decoder_core: serial frames, gaps and noise in,
// decoded display readouts out, checked against an in-bench frame decoder model.
// Depends on mlfd_pkg (types and codes) and the core RTL with its mlfd_decode submodule.
`default_nettype none

module meter_lcd_frame_decoder_core_test
	import mlfd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 480;
	localparam int MIN_READOUTS = 20;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_IDLE     = 18;
	localparam int LONG_HOLD    = 300;

	localparam logic [3:0] CODE_ZERO      = 4'd0;
	localparam logic [3:0] CODE_DIGIT_MAX = 4'd9;

	// Segment patterns indexed by digit code; index CODE_L is L and CODE_BLANK is blank.
	localparam logic [6:0] SEGMENT_TABLE [12] = '{
		7'h7d, 7'h05, 7'h5b, 7'h1f, 7'h27, 7'h3e, 7'h7e, 7'h15, 7'h7f, 7'h3f, 7'h68, 7'h00
	};

	logic      clk;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	meter_lcd_frame_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Frame decoder model state.
	logic [3:0] frame_bytes_seen = '0;
	bit         frame_in_order   = 1'b1;
	logic [3:0] display_nibbles [NIBBLES];

	out_item_t expected_readouts [$];

	int  items_sent        = 0;
	int  readouts_expected = 0;
	int  readouts_checked  = 0;
	int  mismatches        = 0;
	int  count_ok          = 0;
	int  count_bad_seq     = 0;
	int  count_no_num      = 0;
	int  cycle_count       = 0;
	int  hold_request      = 0;
	bit  sender_idle       = 1'b1;
	bit  receiver_idle     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [3:0] pattern_code(input logic [6:0] pattern);
		for (int k = 0; k < 12; k++) begin
			if (SEGMENT_TABLE[k] == pattern)
				return 4'(k);
		end
		return CODE_UNKNOWN;
	endfunction

	function automatic out_item_t decode_display();
		out_item_t  r;
		logic [3:0] codes [DIGIT_COUNT];
		logic [3:0] text [NIBBLES];
		int         len;
		int         pos;
		int         ndig;
		int         frac;
		int         mant;
		bit         point_seen;
		r = '0;
		len = 0;
		pos = 0;
		ndig = 0;
		frac = 0;
		mant = 0;
		point_seen = 1'b0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			codes[i] = pattern_code({display_nibbles[2*i][2:0], display_nibbles[2*i+1]});
			if (display_nibbles[2*i][3]) begin
				r.point_mask[i] = 1'b1;
				text[len] = CODE_POINT;
				len++;
			end
			text[len] = codes[i];
			len++;
		end
		r.digit_a = codes[0];
		r.digit_b = codes[1];
		r.digit_c = codes[2];
		r.digit_d = codes[3];
		while (pos < len && text[pos] == CODE_ZERO)
			pos++;
		// Nothing left after the zeros are stripped reads as a plain zero.
		if (pos == len) begin
			r.status = ST_OK;
			return r;
		end
		while (pos < len && text[pos] == CODE_BLANK)
			pos++;
		while (pos < len) begin
			if (text[pos] <= CODE_DIGIT_MAX) begin
				mant = mant * 10 + int'(text[pos]);
				ndig++;
				if (point_seen)
					frac++;
			end else if (text[pos] == CODE_POINT && !point_seen) begin
				point_seen = 1'b1;
			end else begin
				break;
			end
			pos++;
		end
		if (ndig == 0) begin
			r.status = ST_NO_NUM;
			return r;
		end
		r.status = ST_OK;
		r.mantissa = 14'(mant);
		r.decimals = 3'(frac);
		return r;
	endfunction

	// Advances the model by one accepted transaction; returns 1 when a readout follows.
	function automatic bit advance_frame(input in_item_t it, output out_item_t r);
		logic [3:0] p;
		r = '0;
		if (it.command == CMD_BYTE) begin
			if (frame_bytes_seen != COUNT_MAX) begin
				p = frame_bytes_seen + 4'd1;
				if (it.byte_value[7:4] != p)
					frame_in_order = 1'b0;
				if (p >= FIRST_STORE && p <= LAST_STORE)
					display_nibbles[3'(p - FIRST_STORE)] = it.byte_value[3:0];
				frame_bytes_seen = p;
			end
			return 1'b0;
		end
		if (frame_bytes_seen != FRAME_LEN) begin
			frame_bytes_seen = '0;
			frame_in_order = 1'b1;
			return 1'b0;
		end
		if (!frame_in_order)
			r.status = ST_BAD_SEQ;
		else
			r = decode_display();
		frame_bytes_seen = '0;
		frame_in_order = 1'b1;
		return 1'b1;
	endfunction

	function automatic string fmt_readout(input out_item_t r);
		return $sformatf("st=%0d digits=%0d,%0d,%0d,%0d points=%b mant=%0d dec=%0d",
			r.status, r.digit_a, r.digit_b, r.digit_c, r.digit_d, r.point_mask,
			r.mantissa, r.decimals);
	endfunction

	// Called at the rising edge where the sender's valid was high; returns there after
	// the transaction is accepted.
	task automatic send_item(input logic cmd, input logic [7:0] value);
		int        gap;
		in_item_t  it;
		out_item_t predicted;
		gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.command = cmd;
		it.byte_value = value;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		items_sent++;
		if (advance_frame(it, predicted)) begin
			expected_readouts.push_back(predicted);
			readouts_expected++;
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_readouts.size() != 0);
	endtask

	// Sends bytes 1..length, position in the high nibble but past 15 or at bad_pos, then a gap.
	task automatic send_frame(input logic [3:0][6:0] segs, input logic [3:0] points,
			input int length, input int bad_pos);
		logic [3:0] disp [NIBBLES];
		logic [3:0] hi;
		logic [3:0] lo;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			disp[2*i] = {points[i], segs[i][6:4]};
			disp[2*i+1] = segs[i][3:0];
		end
		for (int p = 1; p <= length; p++) begin
			hi = (p <= 15) ? 4'(p) : 4'($urandom);
			if (p == bad_pos)
				hi = hi ^ 4'($urandom_range(1, 15));
			lo = (p >= 2 && p <= 1 + NIBBLES) ? disp[p - 2] : 4'($urandom);
			send_item(CMD_BYTE, {hi, lo});
		end
		send_item(CMD_GAP, 8'($urandom));
	endtask

	function automatic logic [6:0] pick_pattern();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			return SEGMENT_TABLE[0];
		if (roll < 65)
			return SEGMENT_TABLE[$urandom_range(1, 9)];
		if (roll < 75)
			return SEGMENT_TABLE[CODE_L];
		if (roll < 87)
			return SEGMENT_TABLE[CODE_BLANK];
		return 7'($urandom);
	endfunction

	task automatic send_random_frame();
		int              roll;
		int              n;
		logic [3:0][6:0] segs;
		logic [3:0]      points;
		roll = $urandom_range(0, 99);
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			segs[i] = pick_pattern();
			points[i] = ($urandom_range(0, 3) == 0);
		end
		// A few frames at the ends of the number range: all nines or all zeros.
		if (roll < 5) begin
			segs = {4{SEGMENT_TABLE[9]}};
			points = 4'b0001 << $urandom_range(0, 3);
		end else if (roll < 10) begin
			segs = {4{SEGMENT_TABLE[0]}};
			points = 4'($urandom);
		end
		if (roll < 70) begin
			send_frame(segs, points, FRAME_BYTES, 0);
		end else if (roll < 80) begin
			send_frame(segs, points, FRAME_BYTES, $urandom_range(1, FRAME_BYTES));
		end else if (roll < 88) begin
			send_frame(segs, points, $urandom_range(0, FRAME_BYTES - 1), 0);
		end else if (roll < 94) begin
			send_frame(segs, points, $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6), 0);
		end else begin
			n = $urandom_range(0, 16);
			repeat (n) send_item(CMD_BYTE, 8'($urandom));
			send_item(CMD_GAP, 8'($urandom));
		end
	endtask

	task automatic test_gap_without_frame();
		send_item(CMD_GAP, 8'hff);
		send_frame({4{SEGMENT_TABLE[8]}}, 4'b0000, 3, 0);
	endtask

	task automatic test_all_zero_display();
		send_frame({4{SEGMENT_TABLE[0]}}, 4'b0000, FRAME_BYTES, 0);
	endtask

	task automatic test_random_traffic();
		int start_items;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS || readouts_expected < MIN_READOUTS)
		begin
			if ($urandom_range(0, 7) == 0)
				sender_idle = !sender_idle;
			if ($urandom_range(0, 7) == 0)
				receiver_idle = !receiver_idle;
			send_random_frame();
		end
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	// The receiver holds off while full frames keep coming, so the output register
	// fills and the next gap transaction is stalled at the input.
	task automatic test_output_backpressure();
		sender_idle = 1'b0;
		hold_request = LONG_HOLD;
		repeat (4) send_random_frame();
		repeat (3) send_frame({4{SEGMENT_TABLE[5]}}, 4'b0100, FRAME_BYTES, 0);
		sender_idle = 1'b1;
		wait_drained();
	endtask

	task automatic test_pause_until_drained();
		send_frame({SEGMENT_TABLE[1], SEGMENT_TABLE[2], SEGMENT_TABLE[3], SEGMENT_TABLE[4]},
			4'b0010, FRAME_BYTES, 0);
		wait_drained();
		send_random_frame();
		send_random_frame();
	endtask

	task automatic check_readout(input out_item_t got);
		out_item_t want;
		string     diff;
		if (expected_readouts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected readout with nothing pending: %s", fmt_readout(got));
			return;
		end
		want = expected_readouts.pop_front();
		readouts_checked++;
		case (want.status)
			ST_OK:      count_ok++;
			ST_BAD_SEQ: count_bad_seq++;
			default:    count_no_num++;
		endcase
		diff = "";
		if (got.status !== want.status)         diff = {diff, " status"};
		if (got.digit_a !== want.digit_a)       diff = {diff, " digit_a"};
		if (got.digit_b !== want.digit_b)       diff = {diff, " digit_b"};
		if (got.digit_c !== want.digit_c)       diff = {diff, " digit_c"};
		if (got.digit_d !== want.digit_d)       diff = {diff, " digit_d"};
		if (got.point_mask !== want.point_mask) diff = {diff, " point_mask"};
		if (got.mantissa !== want.mantissa)     diff = {diff, " mantissa"};
		if (got.decimals !== want.decimals)     diff = {diff, " decimals"};
		if (diff != "") begin
			mismatches++;
			if (mismatches <= 10)
				$display("Readout %0d differs in%s: expected %s, got %s", readouts_checked,
					diff, fmt_readout(want), fmt_readout(got));
		end
	endtask

	initial begin : readout_sink
		int hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end else begin
				hold = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			check_readout(result);
		end
	end

	initial begin : watchdog
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d readouts pending", cycle_count,
			expected_readouts.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gap_without_frame();
		test_all_zero_display();
		test_random_traffic();
		test_output_backpressure();
		test_pause_until_drained();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d transactions; checked %0d readouts (ok %0d, bad sequence %0d,",
			items_sent, readouts_checked, count_ok, count_bad_seq);
		$display("no number %0d) over %0d cycles with %0d mismatches.", count_no_num,
			cycle_count, mismatches);
		if (mismatches == 0 && expected_readouts.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
design/mlfd_pkg.sv
design/mlfd_decode.sv
design/meter_lcd_frame_decoder_core.sv
dv/meter_lcd_frame_decoder_core_test.sv
